/* sv/gsa_pkg.sv */
// shared types and constants of the generational slot allocator
package gsa_pkg;

  // field widths of the command and response beats
  localparam int CmdW    = 2;
  localparam int SlotW   = 3;
  localparam int GenW    = 8;
  localparam int StatusW = 2;

  // default pool shape
  localparam int SlotCountDef = 8;
  localparam int GenBitsDef   = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // live bit update request
  typedef struct packed {
    logic clr;
    logic set;
    logic drop;
  } live_op_t;

  // generation memory control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

/* sv/gsa_if.sv */
// command and response channel interfaces of the slot allocator
interface gsa_cmd_if;
  import gsa_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [SlotW-1:0] slot_index;
  logic [GenW-1:0] handle_generation;

  modport source (output valid, output cmd, output slot_index, output handle_generation,
                  input ready);
  modport sink   (input valid, input cmd, input slot_index, input handle_generation,
                  output ready);
endinterface

interface gsa_rsp_if;
  import gsa_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   granted_slot;
  logic [GenW-1:0]    granted_generation;
  logic               handle_live;

  modport source (output valid, output status, output granted_slot,
                  output granted_generation, output handle_live, input ready);
  modport sink   (input valid, input status, input granted_slot,
                  input granted_generation, input handle_live, output ready);
endinterface

/* sv/gsa_gen_mem.sv */
// generation memory with per-entry valid bits so that clear resets every entry together
module gsa_gen_mem #(
  parameter int SLOT_COUNT      = gsa_pkg::SlotCountDef,
  parameter int GENERATION_BITS = gsa_pkg::GenBitsDef,
  localparam int AW             = $clog2(SLOT_COUNT)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gsa_pkg::mem_ctl_t          ctl_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [GENERATION_BITS-1:0] rd_gen_o,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [GENERATION_BITS-1:0] wr_gen_i
);
  import gsa_pkg::*;

  logic [GENERATION_BITS-1:0] mem_q [SLOT_COUNT];
  logic [GENERATION_BITS-1:0] rd_data_q;
  logic [SLOT_COUNT-1:0]      vld_q;
  logic                       rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_gen_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // never-written or cleared entries read as generation zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_gen_o = rd_vld_q ? rd_data_q : '0;

endmodule

/* sv/gsa_live.sv */
// live bits of the pool with lowest-free-slot encoder
module gsa_live #(
  parameter int SLOT_COUNT = gsa_pkg::SlotCountDef,
  localparam int AW        = $clog2(SLOT_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gsa_pkg::live_op_t op_i,
  input  logic [AW-1:0]     addr_i,
  input  logic              in_range_i,
  output logic [AW-1:0]     free_idx_o,
  output logic              full_o,
  output logic              hit_o
);
  import gsa_pkg::*;

  logic [SLOT_COUNT-1:0] live_d, live_q;

  // lowest free slot wins
  always_comb begin
    free_idx_o = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_idx_o = AW'(i);
      end
    end
  end

  assign full_o = &live_q;
  assign hit_o  = in_range_i && live_q[addr_i];

  always_comb begin
    live_d = live_q;
    if (op_i.clr) begin
      live_d = '0;
    end else if (op_i.set) begin
      live_d[free_idx_o] = 1'b1;
    end else if (op_i.drop) begin
      live_d[addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else begin
      live_q <= live_d;
    end
  end

endmodule

/* sv/generational_slot_allocator.sv */
// top level of the generational slot allocator
//
// A pool of SLOT_COUNT slots, each with a live bit and a GENERATION_BITS wide wrapping
// generation; a handle is a slot index plus a generation. Commands arrive as beats on
// req_i (clear, allocate, cancel, query) and each produces exactly one response beat on
// rsp_o. Allocate grants the lowest free slot and returns its current generation, or
// status full; cancel frees a live slot and advances its generation so stale handles die;
// query reports whether a handle is still live. In S_IDLE the accept cycle resolves the
// slot from the live flops and starts the generation memory read; in S_EXEC the block
// uses the registered read data, writes back the advanced generation of a cancelled
// live slot and loads the response register, waiting there while the previous
// response is still held on rsp_o. No new command is taken until the current one has
// left S_EXEC. A new command is accepted while the previous response still waits on
// rsp_o. Clear resets every entry together through per-entry valid bits; there is no
// clearing pass after reset. Slot indices at or beyond SLOT_COUNT count as free slots.
module generational_slot_allocator #(
  parameter int SLOT_COUNT      = gsa_pkg::SlotCountDef,
  parameter int GENERATION_BITS = gsa_pkg::GenBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  gsa_cmd_if.sink         req_i,
  gsa_rsp_if.source       rsp_o
);
  import gsa_pkg::*;

  localparam int AW = $clog2(SLOT_COUNT);
  localparam logic [31:0] GenMask = 32'((64'd1 << GENERATION_BITS) - 64'd1);

  state_e state_d, state_q;

  // command context captured at accept
  cmd_e                       cmd_q;
  logic [AW-1:0]              addr_q;
  logic [GenW-1:0]            hgen_q;
  logic                       hit_q;
  logic                       full_q;

  // response register
  logic                       rsp_valid_q;
  status_e                    rsp_status_q;
  logic [SlotW-1:0]           rsp_slot_q;
  logic [GenW-1:0]            rsp_gen_q;
  logic                       rsp_live_q;

  logic                       acc;
  logic                       load;
  cmd_e                       req_cmd;
  logic [31:0]                idx_ext;
  logic [AW-1:0]              idx_addr;
  logic                       idx_in_range;
  logic [AW-1:0]              free_idx;
  logic                       full;
  logic                       hit;
  logic [AW-1:0]              rd_addr;
  logic [GENERATION_BITS-1:0] rd_gen;
  live_op_t                   live_op;
  mem_ctl_t                   mem_ctl;
  logic [31:0]                grant_ext;
  logic [31:0]                gen_ext;
  logic                       gen_match;

  assign req_cmd      = cmd_e'(req_i.cmd);
  assign req_i.ready  = (state_q == S_IDLE);
  assign acc          = req_i.valid && req_i.ready;

  // slot index mapped onto the pool, out of range reads as a free slot
  assign idx_ext      = 32'(req_i.slot_index);
  assign idx_addr     = idx_ext[AW-1:0];
  assign idx_in_range = idx_ext < 32'(SLOT_COUNT);

  // allocate reads the generation of the slot it grants, others the named slot
  assign rd_addr = (req_cmd == CMD_ALLOC) ? free_idx : idx_addr;

  // live bits change at accept; no command overlaps the next
  assign live_op.clr  = acc && (req_cmd == CMD_CLEAR);
  assign live_op.set  = acc && (req_cmd == CMD_ALLOC) && !full;
  assign live_op.drop = acc && (req_cmd == CMD_CANCEL) && hit;

  // response register free or draining this cycle
  assign load = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);

  assign mem_ctl.rd_en = acc && (req_cmd != CMD_CLEAR);
  assign mem_ctl.clr   = acc && (req_cmd == CMD_CLEAR);
  assign mem_ctl.wr_en = load && (cmd_q == CMD_CANCEL) && hit_q;

  gsa_live #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_live (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (live_op),
    .addr_i     (idx_addr),
    .in_range_i (idx_in_range),
    .free_idx_o (free_idx),
    .full_o     (full),
    .hit_o      (hit)
  );

  gsa_gen_mem #(
    .SLOT_COUNT      (SLOT_COUNT),
    .GENERATION_BITS (GENERATION_BITS)
  ) u_gen_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .rd_gen_o  (rd_gen),
    .wr_addr_i (addr_q),
    .wr_gen_i  (rd_gen + GENERATION_BITS'(1))
  );

  // handle generation is compared after masking to the stored width
  assign gen_ext   = 32'(rd_gen);
  assign gen_match = (gen_ext == (32'(hgen_q) & GenMask));
  assign grant_ext = 32'(addr_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // context of the command in flight; the grant address doubles as the write address
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q  <= req_cmd;
      addr_q <= rd_addr;
      hgen_q <= req_i.handle_generation;
      hit_q  <= hit;
      full_q <= full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_status_q <= ST_OK;
      rsp_slot_q   <= '0;
      rsp_gen_q    <= '0;
      rsp_live_q   <= 1'b0;
      case (cmd_q)
        CMD_ALLOC: begin
          if (full_q) begin
            rsp_status_q <= ST_FULL;
          end else begin
            rsp_slot_q <= grant_ext[SlotW-1:0];
            rsp_gen_q  <= gen_ext[GenW-1:0];
          end
        end
        CMD_CANCEL: begin
          if (!hit_q) begin
            rsp_status_q <= ST_NOT_LIVE;
          end
        end
        CMD_QUERY: begin
          rsp_live_q <= hit_q && gen_match;
        end
        default: begin
          rsp_status_q <= ST_OK;
        end
      endcase
    end
  end

  assign rsp_o.valid              = rsp_valid_q;
  assign rsp_o.status             = rsp_status_q;
  assign rsp_o.granted_slot       = rsp_slot_q;
  assign rsp_o.granted_generation = rsp_gen_q;
  assign rsp_o.handle_live        = rsp_live_q;

  // every accepted command is in the execute state in the following cycle
  a_acc_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q == S_EXEC))
    else $error("accepted command did not reach execute");

  // the generation memory never reads and writes in the same cycle
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.rd_en && mem_ctl.wr_en))
    else $error("generation memory read and write overlap");

  // failed commands grant nothing
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_status_q != ST_OK)) |-> ((rsp_slot_q == '0) && (rsp_gen_q == '0)))
    else $error("grant fields set on failed command");

  // a live handle answer only comes with an ok status
  a_live_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_live_q) |-> (rsp_status_q == ST_OK))
    else $error("handle live with error status");

  // a response is loaded only from the execute state
  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_EXEC))
    else $error("response loaded outside execute");

endmodule

/* verif/generational_slot_allocator_test.sv */
// self-checking testbench of the generational slot allocator
`timescale 1ns / 1ps

module generational_slot_allocator_test;
  import gsa_pkg::*;

  localparam int SLOT_COUNT  = SlotCountDef;
  localparam int GEN_BITS    = GenBitsDef;
  localparam int STALL_LIMIT = 2000;  // cycles without any beat before the run is abandoned
  localparam int DRAIN_WAIT  = 8;     // margin after the drain for late responses
  localparam int MIXED_ITEMS = 120;
  localparam int WRAP_ROUNDS = 258;   // enough cancels on slot 0 to wrap its generation

  // one response beat, in field order
  typedef struct packed {
    status_e             status;
    logic [SlotW-1:0]    slot;
    logic [GenW-1:0]     gen;
    logic                live;
  } alloc_rsp_t;

  // one row of the directed table; typed rows carry their own expected response
  typedef struct packed {
    cmd_e                cmd;
    logic [SlotW-1:0]    idx;
    logic [GenW-1:0]     gen;
    logic                typed;
    alloc_rsp_t          rsp;
  } plan_row_t;

  localparam alloc_rsp_t OK_RSP   = '{ST_OK, 3'd0, 8'd0, 1'b0};
  localparam alloc_rsp_t FULL_RSP = '{ST_FULL, 3'd0, 8'd0, 1'b0};
  localparam alloc_rsp_t FREE_RSP = '{ST_NOT_LIVE, 3'd0, 8'd0, 1'b0};
  localparam alloc_rsp_t NO_RSP   = '0;

  localparam int PLAN_LEN = 22;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{CMD_QUERY,  3'd0, 8'd0,   1'b1, OK_RSP},    // nothing live after reset
    '{CMD_CANCEL, 3'd7, 8'd0,   1'b1, FREE_RSP},  // cancel of a free slot
    '{CMD_ALLOC,  3'd5, 8'd9,   1'b1, OK_RSP},    // first grant is slot 0, generation 0
    '{CMD_ALLOC,  3'd0, 8'd0,   1'b0, NO_RSP},
    '{CMD_ALLOC,  3'd0, 8'd0,   1'b0, NO_RSP},
    '{CMD_ALLOC,  3'd0, 8'd0,   1'b0, NO_RSP},
    '{CMD_ALLOC,  3'd0, 8'd0,   1'b0, NO_RSP},
    '{CMD_ALLOC,  3'd0, 8'd0,   1'b0, NO_RSP},
    '{CMD_ALLOC,  3'd0, 8'd0,   1'b0, NO_RSP},
    '{CMD_ALLOC,  3'd7, 8'd255, 1'b0, NO_RSP},
    '{CMD_ALLOC,  3'd7, 8'd255, 1'b1, FULL_RSP},  // pool full
    '{CMD_QUERY,  3'd7, 8'd0,   1'b0, NO_RSP},
    '{CMD_QUERY,  3'd7, 8'd255, 1'b0, NO_RSP},
    '{CMD_CANCEL, 3'd7, 8'd255, 1'b0, NO_RSP},    // generation not checked on cancel
    '{CMD_CANCEL, 3'd7, 8'd0,   1'b1, FREE_RSP},
    '{CMD_QUERY,  3'd7, 8'd0,   1'b0, NO_RSP},    // stale handle
    '{CMD_ALLOC,  3'd0, 8'd0,   1'b0, NO_RSP},
    '{CMD_QUERY,  3'd7, 8'd1,   1'b0, NO_RSP},
    '{CMD_CLEAR,  3'd7, 8'd255, 1'b1, OK_RSP},
    '{CMD_QUERY,  3'd7, 8'd1,   1'b1, OK_RSP},    // clear drops every handle
    '{CMD_ALLOC,  3'd0, 8'd0,   1'b1, OK_RSP},    // first grant after clear is slot 0, generation 0
    '{CMD_CANCEL, 3'd0, 8'd0,   1'b0, NO_RSP}
  };

  logic clk = 1'b0;
  logic rst_n;

  gsa_cmd_if req_if ();
  gsa_rsp_if rsp_if ();

  generational_slot_allocator #(
    .SLOT_COUNT      (SLOT_COUNT),
    .GENERATION_BITS (GEN_BITS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted pool contents
  logic [SLOT_COUNT-1:0] pool_live;
  logic [GEN_BITS-1:0]   pool_gen [SLOT_COUNT];

  alloc_rsp_t expected_rsps [$];

  // the beat currently on the command channel, as the monitor sees it
  logic       cur_typed;
  alloc_rsp_t cur_rsp;

  int idle_pct = 36;
  int errors = 0;
  int cmd_beats = 0;
  int rsp_beats = 0;
  int full_grants = 0;
  int live_hits = 0;
  int gen_wraps = 0;
  int stall_cycles = 0;

  // applies one command to the predicted pool and returns its response
  function automatic alloc_rsp_t apply_pool_command(cmd_e c, logic [SlotW-1:0] idx,
                                                    logic [GenW-1:0] g);
    alloc_rsp_t r;
    bit         idx_live;
    r = '0;
    idx_live = (int'(idx) < SLOT_COUNT) && pool_live[idx];
    case (c)
      CMD_CLEAR: begin
        pool_live = '0;
        for (int i = 0; i < SLOT_COUNT; i++) pool_gen[i] = '0;
      end
      CMD_ALLOC: begin
        r.status = ST_FULL;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (r.status == ST_FULL && !pool_live[i]) begin
            pool_live[i] = 1'b1;
            r.status = ST_OK;
            r.slot = SlotW'(i);
            r.gen = GenW'(pool_gen[i]);
          end
        end
      end
      CMD_CANCEL: begin
        if (idx_live) begin
          pool_live[idx] = 1'b0;
          pool_gen[idx] = pool_gen[idx] + 1'b1;
          if (pool_gen[idx] == '0) gen_wraps++;
        end else begin
          r.status = ST_NOT_LIVE;
        end
      end
      default: begin
        r.live = idx_live && (pool_gen[idx] == g[GEN_BITS-1:0]);
      end
    endcase
    return r;
  endfunction

  // response checking first, then prediction of the command accepted at this edge
  always @(posedge clk) begin : monitor
    alloc_rsp_t got;
    alloc_rsp_t want;
    logic       cmd_acc;
    logic       rsp_acc;
    if (rst_n) begin
      cmd_acc = req_if.valid && req_if.ready;
      rsp_acc = rsp_if.valid && rsp_if.ready;
      if (rsp_acc) begin
        got = '{status_e'(rsp_if.status), rsp_if.granted_slot, rsp_if.granted_generation,
                rsp_if.handle_live};
        rsp_beats++;
        if (got.status == ST_FULL) full_grants++;
        if (got.live) live_hits++;
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: response beat with none pending: status %0d slot %0d gen %0d live %0d",
                   $time, got.status, got.slot, got.gen, got.live);
        end else begin
          want = expected_rsps.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected status %0d slot %0d gen %0d live %0d",
                     $time, want.status, want.slot, want.gen, want.live);
            $display("%0t:          actual   status %0d slot %0d gen %0d live %0d",
                     $time, got.status, got.slot, got.gen, got.live);
          end
        end
      end
      if (cmd_acc) begin
        want = apply_pool_command(cmd_e'(req_if.cmd), req_if.slot_index,
                                  req_if.handle_generation);
        expected_rsps.push_back(cur_typed ? cur_rsp : want);
        cmd_beats++;
      end
      // watchdog on beats of either channel
      if (cmd_acc || rsp_acc) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat for %0d cycles, %0d responses outstanding",
                   $time, STALL_LIMIT, expected_rsps.size());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // response side back-pressure
  always @(negedge clk) begin
    if (rst_n) rsp_if.ready = ($urandom_range(99) >= idle_pct);
  end

  // drives one command beat; called and returns right after a falling edge, once the beat is taken
  task automatic issue_cmd(cmd_e c, logic [SlotW-1:0] idx, logic [GenW-1:0] g,
                           logic typed, alloc_rsp_t rsp);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.cmd = c;
    req_if.slot_index = idx;
    req_if.handle_generation = g;
    cur_typed = typed;
    cur_rsp = rsp;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // holds the command side until every pending response has arrived
  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int               pick;
    logic [SlotW-1:0] idx;
    logic [GenW-1:0]  g;
    int               live_idx [$];

    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_CLEAR;
    req_if.slot_index = '0;
    req_if.handle_generation = '0;
    rsp_if.ready = 1'b0;
    cur_typed = 1'b0;
    cur_rsp = '0;
    pool_live = '0;
    for (int i = 0; i < SLOT_COUNT; i++) pool_gen[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (DIRECTED_PLAN[i]) begin
      issue_cmd(DIRECTED_PLAN[i].cmd, DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].gen,
                DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].rsp);
    end
    wait_drained();

    // mixed traffic: mostly allocate and cancel of live slots, queries with real handles
    for (int n = 0; n < MIXED_ITEMS; n++) begin
      pick = $urandom_range(99);
      idx = SlotW'($urandom);
      g = GenW'($urandom);
      if (pick < 3) begin
        issue_cmd(CMD_CLEAR, idx, g, 1'b0, NO_RSP);
      end else if (pick < 35) begin
        issue_cmd(CMD_ALLOC, idx, g, 1'b0, NO_RSP);
      end else if (pick < 65) begin
        live_idx.delete();
        for (int i = 0; i < SLOT_COUNT; i++) if (pool_live[i]) live_idx.push_back(i);
        if (live_idx.size() != 0 && $urandom_range(3) != 0)
          idx = SlotW'(live_idx[$urandom_range(live_idx.size() - 1)]);
        issue_cmd(CMD_CANCEL, idx, g, 1'b0, NO_RSP);
      end else begin
        // most queries carry the slot's current generation
        if ($urandom_range(9) < 7) g = GenW'(pool_gen[idx]);
        issue_cmd(CMD_QUERY, idx, g, 1'b0, NO_RSP);
      end
    end
    wait_drained();

    // churn on slot 0 until its generation wraps; the first part runs with no idling
    issue_cmd(CMD_CLEAR, SlotW'($urandom), GenW'($urandom), 1'b0, NO_RSP);
    for (int n = 0; n < WRAP_ROUNDS; n++) begin
      idle_pct = (n < 120) ? 0 : 36;
      issue_cmd(CMD_ALLOC, SlotW'($urandom), GenW'($urandom), 1'b0, NO_RSP);
      if ($urandom_range(99) < 15) begin
        g = ($urandom_range(1) != 0) ? GenW'(pool_gen[0]) : GenW'($urandom);
        issue_cmd(CMD_QUERY, '0, g, 1'b0, NO_RSP);
      end
      issue_cmd(CMD_CANCEL, '0, GenW'($urandom), 1'b0, NO_RSP);
    end
    // stale and fresh handles to the wrapped slot
    issue_cmd(CMD_ALLOC, '0, '0, 1'b0, NO_RSP);
    issue_cmd(CMD_QUERY, '0, GenW'(pool_gen[0]), 1'b0, NO_RSP);
    issue_cmd(CMD_QUERY, '0, GenW'(pool_gen[0] - 1'b1), 1'b0, NO_RSP);

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (expected_rsps.size() != 0) begin
      errors++;
      $display("%0t: %0d expected responses never arrived", $time, expected_rsps.size());
    end

    $display("run covered %0d commands and %0d responses: %0d pool-full answers,",
             cmd_beats, rsp_beats, full_grants);
    $display("%0d live handle hits and %0d generation wraps", live_hits, gen_wraps);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
